[rtl/pist_pkg.sv]
// Package for the periodic item statistics table.
// Holds request/result structs, register indexes and status codes; no dependencies.
`timescale 1ns / 1ps
package pist_pkg;

    // Field widths fixed by the interface
    localparam int ITEM_W  = 6;
    localparam int PHASE_W = 7;
    localparam int VAL_W   = 20;
    localparam int REG_W   = 3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EARLY = 2'd1;
    localparam logic [1:0] ST_BADQ  = 2'd2;

    // Actions
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Configuration register indexes
    typedef enum logic [REG_W-1:0] {
        REG_PERIOD    = 3'd0,
        REG_FIRST     = 3'd1,
        REG_MAX_GAP   = 3'd2,
        REG_MIN_OCC   = 3'd3,
        REG_MIN_PER   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic               action;
        logic [ITEM_W-1:0]  item_id;
        logic [VAL_W-1:0]   timestamp;
        logic [PHASE_W-1:0] query_phase;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [PHASE_W-1:0] phase;
        logic [VAL_W-1:0]   segment;
        logic               known;
        logic [VAL_W-1:0]   occurrences;
        logic [VAL_W-1:0]   periodic_count;
        logic [VAL_W-1:0]   last_segment;
        logic               qualifies;
    } t_res;

    // Configuration seen by front and back
    typedef struct packed {
        logic [PHASE_W-1:0] period_length;
        logic [VAL_W-1:0]   first_timestamp;
        logic [VAL_W-1:0]   max_gap;
        logic [VAL_W-1:0]   min_occurrences;
        logic [VAL_W-1:0]   min_periodic;
    } t_cfg;

    // Classification of a request made by the front
    typedef enum logic [1:0] {
        K_RECORD = 2'd0,
        K_EARLY  = 2'd1,
        K_QUERY  = 2'd2,
        K_BADQ   = 2'd3
    } t_kind;

    // Work item passed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [ITEM_W-1:0]  item;
        logic [PHASE_W-1:0] phase;
        logic [VAL_W-1:0]   segment;
    } t_work;

endpackage

[rtl/periodic_item_stats_table_top.sv]
// Top level of the periodic item statistics table.
// Depends on pist_pkg, pist_fifo, pist_front and pist_back.
//
// Requests enter with push/full: an item is taken when push is high and full
// low. Results leave with empty/pop: the oldest result sits on o_res while
// empty is low and is taken when pop is high. Configuration registers are
// written through i_cfg_valid/o_cfg_ready (always ready) with an index and data.
//
// A record holds the front while the segment and phase come from a divider
// that produces one quotient bit per cycle over 21 bits; then S_FIN finishes
// phase and segment and S_PUSH hands the request off once the work queue has
// room. Queries and early timestamps go straight to S_PUSH. The back end does
// one read-modify-write of the entry table per work item, so the divider sets
// the record rate. The front takes no new request until it leaves S_PUSH.
//
// After reset the seen map is cleared one entry per cycle, all ITEM_COUNT *
// MAX_PERIOD entries (4096 at default sizes); full stays high until then.
// When the receiver stalls, results collect in a two-entry queue, then the
// back end and the front end stop in turn and full rises.
`timescale 1ns / 1ps
module periodic_item_stats_table_top #(
    parameter int ITEM_COUNT  = 64,
    parameter int MAX_PERIOD  = 64,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    input  pist_pkg::t_req                   i_req,
    output logic                             full,
    input  logic                             pop,
    output pist_pkg::t_res                   o_res,
    output logic                             empty,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pist_pkg::REG_W-1:0]       i_cfg_index,
    input  logic [pist_pkg::VAL_W-1:0]       i_cfg_data
);
    localparam int WORK_W = $bits(pist_pkg::t_work);
    localparam int RES_W  = $bits(pist_pkg::t_res);

    pist_pkg::t_cfg  r_cfg;
    logic            front_busy, clearing;
    logic            work_push, work_full, work_pop, work_empty;
    pist_pkg::t_work work_in, work_out;
    logic [WORK_W-1:0] work_q;
    logic            res_push, res_full;
    pist_pkg::t_res  res_in;
    logic [RES_W-1:0] res_q;

    assign o_cfg_ready = 1'b1;
    assign full        = front_busy || clearing;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_length   <= pist_pkg::PHASE_W'(1);
            r_cfg.first_timestamp <= pist_pkg::VAL_W'(1);
            r_cfg.max_gap         <= '0;
            r_cfg.min_occurrences <= '0;
            r_cfg.min_periodic    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pist_pkg::REG_PERIOD: begin
                    r_cfg.period_length <= i_cfg_data[pist_pkg::PHASE_W-1:0];
                end
                pist_pkg::REG_FIRST:   r_cfg.first_timestamp <= i_cfg_data;
                pist_pkg::REG_MAX_GAP: r_cfg.max_gap         <= i_cfg_data;
                pist_pkg::REG_MIN_OCC: r_cfg.min_occurrences <= i_cfg_data;
                pist_pkg::REG_MIN_PER: r_cfg.min_periodic    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pist_front #(
        .ITEM_COUNT (ITEM_COUNT),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push && !full),
        .i_req       (i_req),
        .o_busy      (front_busy),
        .o_work_push (work_push),
        .o_work      (work_in),
        .i_work_full (work_full)
    );

    pist_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (2)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_push),
        .i_data  (work_in),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_data  (work_q),
        .o_empty (work_empty)
    );
    assign work_out = pist_pkg::t_work'(work_q);

    pist_back #(
        .ITEM_COUNT  (ITEM_COUNT),
        .MAX_PERIOD  (MAX_PERIOD),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .o_clearing   (clearing),
        .i_work_empty (work_empty),
        .i_work       (work_out),
        .o_work_pop   (work_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    pist_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );
    assign o_res = pist_pkg::t_res'(res_q);

endmodule

[rtl/pist_fifo.sv]
// Small register queue used between front and back and on the result side.
// Depends on nothing; payload is a flat vector.
`timescale 1ns / 1ps
module pist_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/pist_front.sv]
// Front end: accepts requests, classifies them and computes phase and segment
// with a one-bit-per-cycle divider. Depends on pist_pkg.
`timescale 1ns / 1ps
module pist_front #(
    parameter int ITEM_COUNT = 64,
    parameter int MAX_PERIOD = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pist_pkg::t_cfg  i_cfg,
    input  logic            i_push,
    input  pist_pkg::t_req  i_req,
    output logic            o_busy,
    output logic            o_work_push,
    output pist_pkg::t_work o_work,
    input  logic            i_work_full
);
    localparam int TW = pist_pkg::VAL_W + 1;
    localparam int PH = pist_pkg::PHASE_W;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN, S_PUSH} t_state;

    t_state                  r_state;
    pist_pkg::t_work         r_work;
    logic [TW-1:0]           r_quo;
    logic [PH-1:0]           r_rem;
    logic [PH-1:0]           r_p;
    logic [4:0]              r_cnt;

    logic [PH-1:0]           pe;
    logic [pist_pkg::ITEM_W-1:0] item_mod;
    logic                    early;
    logic [TW-1:0]           t_adj;
    logic [PH:0]             rem2;
    logic                    ge;
    logic [TW:0]             seg_sum;

    // Clamp the period into its legal range
    always_comb begin
        if (i_cfg.period_length == '0) begin
            pe = PH'(1);
        end else if (int'(i_cfg.period_length) > MAX_PERIOD) begin
            pe = PH'(MAX_PERIOD);
        end else begin
            pe = i_cfg.period_length;
        end
    end

    // Wrap the item number, one conditional subtract per bit
    always_comb begin
        item_mod = i_req.item_id;
        for (int k = pist_pkg::ITEM_W - 1; k >= 0; k--) begin
            if (int'(item_mod) >= (ITEM_COUNT << k)) begin
                item_mod = item_mod - pist_pkg::ITEM_W'(ITEM_COUNT << k);
            end
        end
    end

    // Shift the timestamp to adjusted time
    assign early = (i_req.timestamp < i_cfg.first_timestamp);
    assign t_adj = TW'(i_req.timestamp) - TW'(i_cfg.first_timestamp) + TW'(1);

    // Divider step
    assign rem2    = {r_rem, r_quo[TW-1]};
    assign ge      = (rem2 >= {1'b0, r_p});
    assign seg_sum = {1'b0, r_quo} + (TW+1)'(r_rem != '0);

    assign o_busy      = (r_state != S_IDLE);
    assign o_work_push = (r_state == S_PUSH) && !i_work_full;
    assign o_work      = r_work;

    // Sequence accept, divide, finish and hand off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_p             <= pe;
                        r_work.item     <= item_mod;
                        r_work.segment  <= '0;
                        r_quo           <= t_adj;
                        r_rem           <= '0;
                        r_cnt           <= 5'(TW);
                        if (i_req.action == pist_pkg::ACT_QUERY) begin
                            r_state <= S_PUSH;
                            if (i_req.query_phase == '0 || i_req.query_phase > pe) begin
                                r_work.kind  <= pist_pkg::K_BADQ;
                                r_work.phase <= '0;
                            end else begin
                                r_work.kind  <= pist_pkg::K_QUERY;
                                r_work.phase <= i_req.query_phase;
                            end
                        end else if (early) begin
                            r_work.kind  <= pist_pkg::K_EARLY;
                            r_work.phase <= '0;
                            r_state      <= S_PUSH;
                        end else begin
                            r_work.kind  <= pist_pkg::K_RECORD;
                            r_work.phase <= '0;
                            r_state      <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[TW-2:0], ge};
                    r_rem <= ge ? PH'(rem2 - {1'b0, r_p}) : PH'(rem2);
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 5'd1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_work.phase   <= (r_rem == '0) ? r_p : r_rem;
                    r_work.segment <= seg_sum[TW:pist_pkg::VAL_W] != '0 ?
                                      '1 : seg_sum[pist_pkg::VAL_W-1:0];
                    r_state        <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_work_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/pist_back.sv]
// Back end: clears the seen map after reset, then does one read-modify-write
// of the entry table per work item and forms the result. Depends on pist_pkg.
`timescale 1ns / 1ps
module pist_back #(
    parameter int ITEM_COUNT  = 64,
    parameter int MAX_PERIOD  = 64,
    parameter int COUNT_WIDTH = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pist_pkg::t_cfg  i_cfg,
    output logic            o_clearing,
    input  logic            i_work_empty,
    input  pist_pkg::t_work i_work,
    output logic            o_work_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output pist_pkg::t_res  o_res
);
    localparam int DEPTH = ITEM_COUNT * MAX_PERIOD;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = COUNT_WIDTH;
    localparam int VW    = pist_pkg::VAL_W;
    localparam int MW    = (CW > VW) ? CW : VW;

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_CALC} t_state;

    typedef struct packed {
        logic [CW-1:0] occ;
        logic [CW-1:0] per;
        logic [VW-1:0] last;
    } t_entry;

    logic   r_seen_mem [DEPTH];
    t_entry r_ent_mem  [DEPTH];

    t_state          r_state;
    logic [IW:0]     r_clr;
    pist_pkg::t_work r_work;
    logic [IW-1:0]   r_idx;
    logic            r_seen_rd;
    t_entry          r_ent_rd;

    logic [IW-1:0]   head_idx;
    logic            rd_en;
    logic            wr_en;
    t_entry          ent_new;
    logic            gap_ok;
    logic [CW-1:0]   occ_o, per_o;
    pist_pkg::t_res  res;

    assign head_idx = IW'(int'(i_work.item) * MAX_PERIOD + int'(i_work.phase) - 1);
    assign rd_en      = (r_state == B_IDLE) && !i_work_empty;
    assign o_work_pop = rd_en;
    assign o_clearing = (r_state == B_CLEAR);
    assign o_res_push = (r_state == B_CALC) && !i_res_full;
    assign wr_en      = o_res_push && (r_work.kind == pist_pkg::K_RECORD);

    // Update the entry for a record
    assign gap_ok = (r_work.segment <= r_ent_rd.last) ||
                    ((r_work.segment - r_ent_rd.last) <= i_cfg.max_gap);
    always_comb begin
        ent_new.last = r_work.segment;
        if (!r_seen_rd) begin
            ent_new.occ = CW'(1);
            ent_new.per = '0;
        end else begin
            ent_new.occ = (r_ent_rd.occ != '1) ? r_ent_rd.occ + 1'b1 : r_ent_rd.occ;
            ent_new.per = (gap_ok && r_ent_rd.per != '1) ?
                          r_ent_rd.per + 1'b1 : r_ent_rd.per;
        end
    end

    // Form the result
    always_comb begin
        res = '0;
        occ_o = (r_work.kind == pist_pkg::K_RECORD) ? ent_new.occ : r_ent_rd.occ;
        per_o = (r_work.kind == pist_pkg::K_RECORD) ? ent_new.per : r_ent_rd.per;
        case (r_work.kind)
            pist_pkg::K_EARLY: begin
                res.status = pist_pkg::ST_EARLY;
            end
            pist_pkg::K_BADQ: begin
                res.status = pist_pkg::ST_BADQ;
            end
            pist_pkg::K_RECORD: begin
                res.status       = pist_pkg::ST_OK;
                res.phase        = r_work.phase;
                res.segment      = r_work.segment;
                res.known        = 1'b1;
                res.occurrences  = VW'(occ_o);
                res.periodic_count = VW'(per_o);
                res.last_segment = r_work.segment;
                res.qualifies    = (MW'(occ_o) >= MW'(i_cfg.min_occurrences)) &&
                                   (MW'(per_o) >= MW'(i_cfg.min_periodic));
            end
            default: begin
                res.status = pist_pkg::ST_OK;
                res.phase  = r_work.phase;
                if (r_seen_rd) begin
                    res.known          = 1'b1;
                    res.occurrences    = VW'(occ_o);
                    res.periodic_count = VW'(per_o);
                    res.last_segment   = r_ent_rd.last;
                    res.qualifies = (MW'(occ_o) >= MW'(i_cfg.min_occurrences)) &&
                                    (MW'(per_o) >= MW'(i_cfg.min_periodic));
                end
            end
        endcase
    end
    assign o_res = res;

    // Sequence clearing pass, read and update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (IW+1)'(DEPTH - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (rd_en) begin
                        r_work  <= i_work;
                        r_idx   <= head_idx;
                        r_state <= B_CALC;
                    end
                end
                B_CALC: begin
                    if (o_res_push) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // Seen map: cleared by the pass, set by records
    always_ff @(posedge i_clk) begin
        if (r_state == B_CLEAR) begin
            r_seen_mem[r_clr[IW-1:0]] <= 1'b0;
        end else if (wr_en) begin
            r_seen_mem[r_idx] <= 1'b1;
        end
        if (rd_en) begin
            r_seen_rd <= r_seen_mem[head_idx];
        end
    end

    // Entry table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ent_mem[r_idx] <= ent_new;
        end
        if (rd_en) begin
            r_ent_rd <= r_ent_mem[head_idx];
        end
    end

    // No result leaves and no work item is popped during the clearing pass
    a_no_res_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_res_push && !o_work_pop)
        else $error("result or pop during clearing pass");

    // A popped work item puts the back end in B_CALC in the next cycle
    a_pop_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_work_pop |=> (r_state == B_CALC))
        else $error("popped work item not processed");

    // A stalled result keeps its state and payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CALC && i_res_full) |=> (r_state == B_CALC) && $stable(r_work))
        else $error("work item lost while result side stalled");

    // Records always report a known entry with a nonzero count
    a_record_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && r_work.kind == pist_pkg::K_RECORD) |->
            (o_res.known && ent_new.occ != '0))
        else $error("record result without a counted entry");

endmodule

[dv/tb.sv]
// Testbench for periodic_item_stats_table_top: directed and random requests checked
// against an in-bench model of the statistics table. Depends on pist_pkg and the RTL.
`timescale 1ns / 1ps
module tb;

    localparam int ITEMS     = 64;
    localparam int PERIODS   = 64;
    localparam int DEPTH     = ITEMS * PERIODS;
    localparam int VAL_MAX   = 1048575;
    localparam int WDOG_MAX  = 20000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         push;
    pist_pkg::t_req               i_req;
    logic                         full;
    logic                         pop;
    pist_pkg::t_res               o_res;
    logic                         empty;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [pist_pkg::REG_W-1:0]   i_cfg_index;
    logic [pist_pkg::VAL_W-1:0]   i_cfg_data;

    // Model state of the table
    bit                           seen_tab [DEPTH];
    logic [pist_pkg::VAL_W-1:0]   occ_tab  [DEPTH];
    logic [pist_pkg::VAL_W-1:0]   per_tab  [DEPTH];
    logic [pist_pkg::VAL_W-1:0]   last_tab [DEPTH];
    logic [pist_pkg::PHASE_W-1:0] m_period;
    logic [pist_pkg::VAL_W-1:0]   m_first;
    logic [pist_pkg::VAL_W-1:0]   m_max_gap;
    logic [pist_pkg::VAL_W-1:0]   m_min_occ;
    logic [pist_pkg::VAL_W-1:0]   m_min_per;

    pist_pkg::t_res               pending_results [$];
    int                           fail_cnt;
    int                           stall_cnt;
    int                           rx_hold;
    bit                           tx_idle_on;
    bit                           rx_idle_on;

    periodic_item_stats_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_req       (i_req),
        .full        (full),
        .pop         (pop),
        .o_res       (o_res),
        .empty       (empty),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int eff_period();
        if (m_period == 0) return 1;
        if (int'(m_period) > PERIODS) return PERIODS;
        return int'(m_period);
    endfunction

    // Append one expected result behind the ones already waiting
    function automatic void add_expected(input pist_pkg::t_res e);
        pending_results.insert(pending_results.size(), e);
    endfunction

    // Update the model with one request and return the result it produces
    function automatic pist_pkg::t_res stats_update(pist_pkg::t_req r);
        pist_pkg::t_res e;
        int   p;
        int   t;
        int   ph;
        int   seg;
        int   idx;
        e = '0;
        p = eff_period();
        if (r.action == pist_pkg::ACT_RECORD) begin
            if (r.timestamp < m_first) begin
                e.status = pist_pkg::ST_EARLY;
                return e;
            end
            t   = int'(r.timestamp) - int'(m_first) + 1;
            ph  = t % p;
            if (ph == 0) ph = p;
            seg = (t + p - 1) / p;
            if (seg > VAL_MAX) seg = VAL_MAX;
            idx = int'(r.item_id) * PERIODS + ph - 1;
            if (!seen_tab[idx]) begin
                seen_tab[idx] = 1'b1;
                occ_tab[idx]  = pist_pkg::VAL_W'(1);
                per_tab[idx]  = '0;
            end else begin
                if (int'(occ_tab[idx]) != VAL_MAX) occ_tab[idx]++;
                if ((seg <= int'(last_tab[idx]) || seg - int'(last_tab[idx]) <= int'(m_max_gap))
                    && int'(per_tab[idx]) != VAL_MAX)
                    per_tab[idx]++;
            end
            last_tab[idx] = pist_pkg::VAL_W'(seg);
            e.status  = pist_pkg::ST_OK;
            e.phase   = pist_pkg::PHASE_W'(ph);
            e.segment = pist_pkg::VAL_W'(seg);
        end else begin
            if (r.query_phase == 0 || int'(r.query_phase) > p) begin
                e.status = pist_pkg::ST_BADQ;
                return e;
            end
            e.phase = r.query_phase;
            idx = int'(r.item_id) * PERIODS + int'(r.query_phase) - 1;
            if (!seen_tab[idx]) return e;
        end
        e.known          = 1'b1;
        e.occurrences    = occ_tab[idx];
        e.periodic_count = per_tab[idx];
        e.last_segment   = last_tab[idx];
        e.qualifies      = (occ_tab[idx] >= m_min_occ) && (per_tab[idx] >= m_min_per);
        return e;
    endfunction

    // Send one request with a random lead-in gap; push stays high after acceptance
    task automatic send_item(input pist_pkg::t_req r);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push  = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (full);
        add_expected(stats_update(r));
        @(negedge i_clk);
    endtask

    // Drop push and wait until every expected result has come back
    task automatic wait_drain();
        push = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input pist_pkg::t_reg_idx idx, input int data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = pist_pkg::VAL_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pist_pkg::REG_PERIOD:  m_period  = pist_pkg::PHASE_W'(data);
            pist_pkg::REG_FIRST:   m_first   = pist_pkg::VAL_W'(data);
            pist_pkg::REG_MAX_GAP: m_max_gap = pist_pkg::VAL_W'(data);
            pist_pkg::REG_MIN_OCC: m_min_occ = pist_pkg::VAL_W'(data);
            pist_pkg::REG_MIN_PER: m_min_per = pist_pkg::VAL_W'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input int p, input int first, input int gap, input int mo,
                             input int mp);
        wait_drain();
        write_reg(pist_pkg::REG_PERIOD, p);
        write_reg(pist_pkg::REG_FIRST, first);
        write_reg(pist_pkg::REG_MAX_GAP, gap);
        write_reg(pist_pkg::REG_MIN_OCC, mo);
        write_reg(pist_pkg::REG_MIN_PER, mp);
    endtask

    function automatic pist_pkg::t_req mk(input logic act, input int item, input int ts,
                                          input int qp);
        pist_pkg::t_req r;
        r.action      = act;
        r.item_id     = pist_pkg::ITEM_W'(item);
        r.timestamp   = pist_pkg::VAL_W'(ts);
        r.query_phase = pist_pkg::PHASE_W'(qp);
        return r;
    endfunction

    // Reset configuration: early timestamp, repeats, bad and unknown queries
    task automatic test_reset_defaults();
        send_item(mk(pist_pkg::ACT_RECORD, 0, 0, 0));
        send_item(mk(pist_pkg::ACT_RECORD, 0, 1, 0));
        send_item(mk(pist_pkg::ACT_RECORD, 0, 1, 0));
        send_item(mk(pist_pkg::ACT_QUERY, 0, 0, 1));
        send_item(mk(pist_pkg::ACT_QUERY, 0, 0, 0));
        send_item(mk(pist_pkg::ACT_QUERY, 0, 0, 2));
        send_item(mk(pist_pkg::ACT_QUERY, 5, 0, 1));
    endtask

    // Field extremes, out-of-range periods, segment going back and overflow
    task automatic test_extremes();
        configure(64, 0, 0, 2, 1);
        send_item(mk(pist_pkg::ACT_RECORD, 63, 0, 0));
        send_item(mk(pist_pkg::ACT_RECORD, 63, 64, 0));
        send_item(mk(pist_pkg::ACT_RECORD, 63, 0, 0));
        send_item(mk(pist_pkg::ACT_QUERY, 63, 0, 1));
        send_item(mk(pist_pkg::ACT_QUERY, 63, 0, 64));
        send_item(mk(pist_pkg::ACT_QUERY, 63, 0, 65));
        send_item(mk(pist_pkg::ACT_QUERY, 63, 0, 127));
        configure(0, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        send_item(mk(pist_pkg::ACT_RECORD, 42, VAL_MAX, 0));
        send_item(mk(pist_pkg::ACT_RECORD, 42, 0, 0));
        send_item(mk(pist_pkg::ACT_QUERY, 42, 0, 1));
        configure(127, 3, 1, 0, 0);
        send_item(mk(pist_pkg::ACT_RECORD, 21, VAL_MAX, 0));
        send_item(mk(pist_pkg::ACT_QUERY, 21, 0, 64));
        send_item(mk(pist_pkg::ACT_QUERY, 21, 0, 65));
        configure(1, 0, 0, 1, 0);
        send_item(mk(pist_pkg::ACT_RECORD, 1, VAL_MAX, 0));
        send_item(mk(pist_pkg::ACT_RECORD, 1, VAL_MAX, 0));
        send_item(mk(pist_pkg::ACT_QUERY, 1, 0, 1));
    endtask

    // Mostly repeated keys near the start time, with early stamps and bad queries
    task automatic test_random(input int n, input int p, input int first, input int gap,
                               input int mo, input int mp);
        pist_pkg::t_req r;
        int   k;
        int   pe;
        int   ts;
        configure(p, first, gap, mo, mp);
        pe = eff_period();
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (i == n / 2) wait_drain();
            k = $urandom_range(0, 99);
            r = mk(pist_pkg::ACT_RECORD, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                                     : $urandom_range(0, 5),
                   $urandom_range(0, VAL_MAX), $urandom_range(0, 127));
            if (k < 70) begin
                ts = first + $urandom_range(0, pe * 12);
                r.timestamp = pist_pkg::VAL_W'((ts > VAL_MAX) ? VAL_MAX : ts);
            end else if (k < 76) begin
                r.timestamp = pist_pkg::VAL_W'((first > 0) ? $urandom_range(0, first - 1) : 0);
            end else if (k < 94) begin
                r.action = pist_pkg::ACT_QUERY;
                r.query_phase = pist_pkg::PHASE_W'($urandom_range(1, pe));
            end else if (k < 97) begin
                r.action = pist_pkg::ACT_QUERY;
            end
            send_item(r);
        end
    endtask

    // Stall the receiver for a long stretch while requests keep coming
    task automatic test_backpressure();
        wait_drain();
        tx_idle_on = 0;
        rx_hold    = 400;
        for (int i = 0; i < 30; i++)
            send_item(mk(pist_pkg::ACT_RECORD, $urandom_range(0, 3),
                         int'(m_first) + $urandom_range(0, 50), $urandom_range(0, 127)));
        wait_drain();
    endtask

    // Receiver: random stall per result, with an optional long hold
    initial begin
        int gap;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                pop = 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Compare each accepted result with the oldest expectation; watch for a hang
    always @(posedge i_clk) begin
        pist_pkg::t_res e;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_cnt++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", int'(e.status), int'(o_res.status));
                check_field("phase", int'(e.phase), int'(o_res.phase));
                check_field("segment", int'(e.segment), int'(o_res.segment));
                check_field("known", int'(e.known), int'(o_res.known));
                check_field("occurrences", int'(e.occurrences), int'(o_res.occurrences));
                check_field("periodic_count", int'(e.periodic_count),
                            int'(o_res.periodic_count));
                check_field("last_segment", int'(e.last_segment), int'(o_res.last_segment));
                check_field("qualifies", int'(e.qualifies), int'(o_res.qualifies));
            end
        end
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= WDOG_MAX) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        fail_cnt    = 0;
        stall_cnt   = 0;
        rx_hold     = 0;
        tx_idle_on  = 1;
        rx_idle_on  = 1;
        m_period    = pist_pkg::PHASE_W'(1);
        m_first     = pist_pkg::VAL_W'(1);
        m_max_gap   = '0;
        m_min_occ   = '0;
        m_min_per   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_extremes();
        test_random(120, 7, 1000, 1, 3, 1);
        test_backpressure();
        test_random(120, 64, 1040000, 0, 1, 0);
        test_random(120, 0, 0, VAL_MAX, VAL_MAX, VAL_MAX);
        test_random(120, 127, 50, 2, 2, 2);
        test_random(120, 13, 524288, 3, 4, 2);
        wait_drain();

        if (fail_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
